// ===== src/eil_pkg.sv =====
package eil_pkg;

    // operation codes carried in s_tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // configuration register indexes
    localparam logic REG_TABLE_BASE  = 1'b0;
    localparam logic REG_ENTRY_COUNT = 1'b1;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W    = 11;
    localparam int SLOT_W     = 10;
    localparam int WORD_W     = 32;

    // input tdata layout, lowest bit first
    localparam int IN_SLOT_LO = 0;
    localparam int IN_FW_LO   = IN_SLOT_LO + SLOT_W;
    localparam int IN_DW_LO   = IN_FW_LO + WORD_W;
    localparam int IN_PC_LO   = IN_DW_LO + WORD_W;
    localparam int IN_BITS    = IN_PC_LO + WORD_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OUT_IDX_LO = 0;
    localparam int OUT_FA_LO  = OUT_IDX_LO + SLOT_W;
    localparam int OUT_UD_LO  = OUT_FA_LO + WORD_W;
    localparam int OUT_BITS   = OUT_UD_LO + WORD_W;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_MISS,
        RES_HIT
    } res_kind_t;

    typedef struct packed {
        logic      init;
        logic      wr;
        logic      issue;
        logic      fetch_best;
        logic      step;
        logic      load;
        res_kind_t kind;
    } eil_cmd_t;

    typedef struct packed {
        logic lo_lt_hi;
        logic lo_zero;
        logic out_free;
    } eil_sts_t;

endpackage

// ===== src/exception_index_lookup.sv =====
// A write beat's result is put on m_tvalid once the output register is free; a search
// makes at most P = ceil(log2(n+1)) probes for n entries (11 at 1024), then on a hit
// reads back the entry below the upper bound. It takes one beat at a time; the next beat
// is taken the cycle after the result is loaded into the output register. Each probe
// is one read of the entry RAM and then one address add and compare.
// Reset clears control state and the config registers; table contents stay undefined.
module exception_index_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [eil_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [eil_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index, function_word, data_word, program_counter
    input  logic [eil_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // found_index, function_address, unwind_data
    output logic [eil_pkg::M_TDATA_W-1:0]     m_tdata,
    // status, is_inline
    output logic [eil_pkg::M_TUSER_W-1:0]     m_tuser
);

    eil_pkg::eil_cmd_t cmd;
    eil_pkg::eil_sts_t sts;

    eil_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    eil_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== src/eil_ram.sv =====
module eil_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/eil_ctrl.sv =====
module eil_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  eil_pkg::eil_sts_t sts,
    output eil_pkg::eil_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_EVAL,
        S_EMIT
    } state_t;

    state_t              state_reg;
    eil_pkg::res_kind_t  kind_reg;
    logic                accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd = '0;
        cmd.kind = kind_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.init = accept && (s_tuser == eil_pkg::OP_SEARCH);
                cmd.wr   = accept && (s_tuser == eil_pkg::OP_WRITE);
            end
            S_PROBE: begin
                if (sts.lo_lt_hi) begin
                    cmd.issue = 1'b1;
                end else if (!sts.lo_zero) begin
                    // search done, read back the entry before the upper bound
                    cmd.issue      = 1'b1;
                    cmd.fetch_best = 1'b1;
                end
            end
            S_EVAL: begin
                cmd.step = 1'b1;
            end
            S_EMIT: begin
                cmd.load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg  <= eil_pkg::RES_ZERO;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_tuser == eil_pkg::OP_SEARCH) begin
                            state_reg <= S_PROBE;
                        end else begin
                            kind_reg  <= eil_pkg::RES_ZERO;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_PROBE: begin
                    if (sts.lo_lt_hi) begin
                        state_reg <= S_EVAL;
                    end else if (sts.lo_zero) begin
                        kind_reg  <= eil_pkg::RES_MISS;
                        state_reg <= S_EMIT;
                    end else begin
                        kind_reg  <= eil_pkg::RES_HIT;
                        state_reg <= S_EMIT;
                    end
                end
                S_EVAL: begin
                    state_reg <= S_PROBE;
                end
                S_EMIT: begin
                    if (sts.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/eil_dp.sv =====
module eil_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [eil_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [eil_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [eil_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [eil_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [eil_pkg::M_TUSER_W-1:0]     m_tuser,
    input  eil_pkg::eil_cmd_t                 cmd,
    output eil_pkg::eil_sts_t                 sts
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 2 * eil_pkg::WORD_W;

    logic [eil_pkg::WORD_W-1:0]  base_reg;
    logic [eil_pkg::COUNT_W-1:0] count_reg;

    logic [CW-1:0]               lo_reg, hi_reg, idx_reg;
    logic [CW-1:0]               mid, probe_idx, n_clamped;
    logic [eil_pkg::WORD_W-1:0]  pc_reg, eaddr_reg, fn_addr;

    logic [eil_pkg::SLOT_W-1:0]  in_slot;
    logic [eil_pkg::WORD_W-1:0]  in_fw, in_dw, in_pc;
    logic                        ram_we;
    logic [EW-1:0]               ram_rdata;
    logic [eil_pkg::WORD_W-1:0]  rd_fw, rd_dw;

    logic                        m_valid_reg;
    logic                        status_reg, inline_reg;
    logic [eil_pkg::SLOT_W-1:0]  idx_out_reg;
    logic [eil_pkg::WORD_W-1:0]  fa_out_reg, ud_out_reg;

    assign in_slot = s_tdata[eil_pkg::IN_SLOT_LO +: eil_pkg::SLOT_W];
    assign in_fw   = s_tdata[eil_pkg::IN_FW_LO +: eil_pkg::WORD_W];
    assign in_dw   = s_tdata[eil_pkg::IN_DW_LO +: eil_pkg::WORD_W];
    assign in_pc   = s_tdata[eil_pkg::IN_PC_LO +: eil_pkg::WORD_W];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                eil_pkg::REG_TABLE_BASE:  base_reg  <= cfg_wdata;
                eil_pkg::REG_ENTRY_COUNT: count_reg <= cfg_wdata[eil_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(count_reg) > 32'(TABLE_DEPTH)) begin
            n_clamped = CW'(TABLE_DEPTH);
        end else begin
            n_clamped = CW'(count_reg);
        end
    end

    assign ram_we = cmd.wr && (32'(in_slot) < 32'(TABLE_DEPTH));

    eil_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(in_slot)),
        .wdata ({in_dw, in_fw}),
        .re    (cmd.issue),
        .raddr (probe_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_fw = ram_rdata[eil_pkg::WORD_W-1:0];
    assign rd_dw = ram_rdata[EW-1:eil_pkg::WORD_W];

    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign probe_idx = cmd.fetch_best ? (lo_reg - CW'(1)) : mid;

    // prel31 offset, sign-extended from bit 30
    assign fn_addr = eaddr_reg + {rd_fw[30], rd_fw[30:0]};

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            lo_reg <= '0;
            hi_reg <= n_clamped;
            pc_reg <= in_pc;
        end else if (cmd.step) begin
            if (pc_reg < fn_addr) begin
                hi_reg <= idx_reg;
            end else begin
                lo_reg <= idx_reg + CW'(1);
            end
        end
        if (cmd.issue) begin
            idx_reg   <= probe_idx;
            eaddr_reg <= base_reg + (32'(probe_idx) << 3);
        end
    end

    assign sts.lo_lt_hi = (lo_reg < hi_reg);
    assign sts.lo_zero  = (lo_reg == '0);
    assign sts.out_free = !m_valid_reg || m_tready;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            case (cmd.kind)
                eil_pkg::RES_HIT: begin
                    status_reg  <= 1'b0;
                    idx_out_reg <= eil_pkg::SLOT_W'(idx_reg);
                    fa_out_reg  <= fn_addr;
                    if (rd_dw[31]) begin
                        ud_out_reg <= rd_dw;
                        inline_reg <= 1'b1;
                    end else begin
                        ud_out_reg <= {rd_dw[30], rd_dw[30:0]};
                        inline_reg <= 1'b0;
                    end
                end
                eil_pkg::RES_MISS: begin
                    status_reg  <= 1'b1;
                    idx_out_reg <= '0;
                    fa_out_reg  <= '0;
                    ud_out_reg  <= '0;
                    inline_reg  <= 1'b0;
                end
                default: begin
                    status_reg  <= 1'b0;
                    idx_out_reg <= '0;
                    fa_out_reg  <= '0;
                    ud_out_reg  <= '0;
                    inline_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = eil_pkg::M_TDATA_W'({ud_out_reg, fa_out_reg, idx_out_reg});
    assign m_tuser  = {inline_reg, status_reg};

endmodule

// ===== test/tb_exception_index_lookup.sv =====
module tb_exception_index_lookup;

    localparam int DEPTH          = 1024;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_MISS  = 1'b1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 40;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 45;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_COUNTS [NUM_PHASES] = '{1, 3, 0, 16, 64, 300, 200, 300, 7, 255};
    localparam int NUM_DIR        = 24;

    typedef struct packed {
        logic                       op;
        logic [eil_pkg::SLOT_W-1:0] slot;
        logic [eil_pkg::WORD_W-1:0] fn_word;
        logic [eil_pkg::WORD_W-1:0] data_word;
        logic [eil_pkg::WORD_W-1:0] pc;
    } lookup_req_t;

    typedef struct packed {
        logic                       status;
        logic [eil_pkg::SLOT_W-1:0] idx;
        logic [eil_pkg::WORD_W-1:0] fn_addr;
        logic [eil_pkg::WORD_W-1:0] unwind;
        logic                       inline_flag;
    } lookup_res_t;

    typedef struct packed {
        logic                           is_cfg;
        logic [eil_pkg::CFG_ADDR_W-1:0] reg_sel;
        logic [eil_pkg::CFG_DATA_W-1:0] reg_val;
        lookup_req_t                    rq;
        logic                           typed;
        lookup_res_t                    res;
    } dir_row_t;

    localparam lookup_res_t ZERO_RES = '0;
    localparam lookup_res_t MISS_RES = '{STATUS_MISS, '0, '0, '0, 1'b0};

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [eil_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [eil_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [eil_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [eil_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [eil_pkg::M_TUSER_W-1:0]  m_tuser;

    exception_index_lookup dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // shadow copy of the block's table and registers
    logic [63:0]                 entry_mem [0:DEPTH-1];
    logic [eil_pkg::WORD_W-1:0]  tbl_base;
    logic [eil_pkg::COUNT_W-1:0] tbl_count;

    lookup_res_t pending [$];
    dir_row_t    dir_tab [NUM_DIR];
    int          filled;
    bit          tx_burst;
    int          mismatches;
    int          n_results;
    int          n_writes;
    int          n_hits;
    int          n_misses;
    int          n_inline;

    function automatic logic [31:0] prel31(input logic [31:0] w);
        return {w[30], w[30:0]};
    endfunction

    function automatic logic [31:0] fn_addr_at(input int unsigned i);
        return tbl_base + 32'(i * 8) + prel31(entry_mem[i][31:0]);
    endfunction

    // upper-bound search over the effective entry count
    function automatic lookup_res_t predict_lookup(input lookup_req_t rq);
        lookup_res_t r;
        int unsigned lo, hi, mid;
        logic [31:0] dw;
        r = '0;
        if (rq.op == eil_pkg::OP_WRITE) begin
            entry_mem[rq.slot] = {rq.data_word, rq.fn_word};
            return r;
        end
        lo = 0;
        hi = (tbl_count > DEPTH) ? DEPTH : tbl_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (rq.pc < fn_addr_at(mid)) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        if (lo == 0) begin
            r.status = STATUS_MISS;
            return r;
        end
        dw            = entry_mem[lo - 1][63:32];
        r.status      = STATUS_OK;
        r.idx         = eil_pkg::SLOT_W'(lo - 1);
        r.fn_addr     = fn_addr_at(lo - 1);
        r.inline_flag = dw[31];
        r.unwind      = dw[31] ? dw : prel31(dw);
        return r;
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function automatic dir_row_t cfg_row(input logic [eil_pkg::CFG_ADDR_W-1:0] sel,
                                         input logic [31:0] val);
        dir_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    function automatic dir_row_t req_row(input logic op, input logic [9:0] slot,
                                         input logic [31:0] fw, input logic [31:0] dw,
                                         input logic [31:0] pc);
        dir_row_t r;
        r    = '0;
        r.rq = '{op, slot, fw, dw, pc};
        return r;
    endfunction

    function automatic dir_row_t chk_row(input dir_row_t row, input lookup_res_t res);
        dir_row_t r;
        r       = row;
        r.typed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    function automatic lookup_res_t hit_res(input logic [9:0] idx, input logic [31:0] fa,
                                            input logic [31:0] ud, input logic inl);
        lookup_res_t r;
        r = '{STATUS_OK, idx, fa, ud, inl};
        return r;
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_req(input lookup_req_t rq, input bit typed = 1'b0,
                            input lookup_res_t given = '0);
        int gap;
        logic [eil_pkg::S_TDATA_W-1:0] word;
        lookup_res_t want;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        word = '0;
        word[eil_pkg::IN_SLOT_LO +: eil_pkg::SLOT_W] = rq.slot;
        word[eil_pkg::IN_FW_LO +: eil_pkg::WORD_W]   = rq.fn_word;
        word[eil_pkg::IN_DW_LO +: eil_pkg::WORD_W]   = rq.data_word;
        word[eil_pkg::IN_PC_LO +: eil_pkg::WORD_W]   = rq.pc;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= rq.op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_lookup(rq);
        if (rq.op == eil_pkg::OP_WRITE) begin
            n_writes++;
        end else if (want.status == STATUS_MISS) begin
            n_misses++;
        end else begin
            n_hits++;
            if (want.inline_flag) n_inline++;
        end
        pending.push_back(typed ? given : want);
        @(negedge aclk);
    endtask

    // drop valid and wait until every outstanding result is back
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [eil_pkg::CFG_ADDR_W-1:0] sel,
                             input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= sel;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (sel == eil_pkg::REG_TABLE_BASE) begin
            tbl_base = val;
        end else begin
            tbl_count = val[eil_pkg::COUNT_W-1:0];
        end
        @(negedge aclk);
    endtask

    // entries 0..n-1 with non-decreasing function addresses; offsets stay well inside prel31
    task automatic lay_sorted_table(input int n);
        lookup_req_t rq;
        logic [31:0] fa, off;
        int i;
        fa = tbl_base + $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        for (i = 0; i < n; i++) begin
            off = fa - (tbl_base + 32'(i * 8));
            rq  = '{eil_pkg::OP_WRITE, eil_pkg::SLOT_W'(i),
                    {1'($urandom_range(0, 1)), off[30:0]}, $urandom, $urandom};
            send_req(rq);
            fa += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 4096);
        end
        if (n > filled) filled = n;
    endtask

    // result side: random stalls, one long hold, checks against the oldest expectation
    initial begin
        int stall;
        bit late, rx_burst;
        lookup_res_t got, want;
        m_tready = 1'b0;
        rx_burst = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (n_results % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 5);
            late  = !rx_burst && ($urandom_range(0, 1) == 1);
            if (n_results == HOLD_AT) stall = HOLD_CYCLES;
            if (late || stall > 0) begin
                m_tready <= 1'b0;
                if (late) begin
                    @(posedge aclk);
                    while (!m_tvalid) @(posedge aclk);
                    @(negedge aclk);
                end
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.status      = m_tuser[0];
            got.inline_flag = m_tuser[1];
            got.idx         = m_tdata[eil_pkg::OUT_IDX_LO +: eil_pkg::SLOT_W];
            got.fn_addr     = m_tdata[eil_pkg::OUT_FA_LO +: eil_pkg::WORD_W];
            got.unwind      = m_tdata[eil_pkg::OUT_UD_LO +: eil_pkg::WORD_W];
            if (pending.size() == 0) begin
                flag_error($sformatf("beat %0d: result with nothing outstanding (st=%b idx=%0d)",
                                     n_results, got.status, got.idx));
            end else begin
                want = pending.pop_front();
                if (got.status !== want.status || got.idx !== want.idx ||
                    got.fn_addr !== want.fn_addr || got.unwind !== want.unwind ||
                    got.inline_flag !== want.inline_flag) begin
                    flag_error($sformatf({"beat %0d: expected st=%b idx=%0d fa=%h ud=%h inl=%b,",
                                          " got st=%b idx=%0d fa=%h ud=%h inl=%b"},
                        n_results, want.status, want.idx, want.fn_addr, want.unwind,
                        want.inline_flag, got.status, got.idx, got.fn_addr, got.unwind,
                        got.inline_flag));
                end
            end
            n_results++;
            @(negedge aclk);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        int p, k, n, pick, largest;
        lookup_req_t rq;
        logic [31:0] fa;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = eil_pkg::OP_WRITE;
        cfg_wr_en  = 1'b0;
        cfg_addr   = eil_pkg::REG_TABLE_BASE;
        cfg_wdata  = '0;
        tbl_base   = '0;
        tbl_count  = '0;
        tx_burst   = 1'b0;
        filled     = 0;
        largest    = 4;
        mismatches = 0;
        n_results  = 0;
        n_writes   = 0;
        n_hits     = 0;
        n_misses   = 0;
        n_inline   = 0;

        // entry 0 at 0x10 (inline), entry 1 at 0x108, entry 2 at the largest
        // positive offset, entry 3 at the most negative one
        dir_tab = '{
            chk_row(req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, 32'h0), MISS_RES),
            chk_row(req_row(eil_pkg::OP_SEARCH, 10'h3FF, '1, '1, '1), MISS_RES),
            chk_row(req_row(eil_pkg::OP_WRITE, 10'd0, 32'h0000_0010, 32'h80AB_CDEF, 32'h0),
                    ZERO_RES),
            chk_row(req_row(eil_pkg::OP_WRITE, 10'd1, 32'h8000_0100, 32'h4000_0000, '1),
                    ZERO_RES),
            chk_row(req_row(eil_pkg::OP_WRITE, 10'd2, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h0),
                    ZERO_RES),
            chk_row(req_row(eil_pkg::OP_WRITE, 10'h3FF, '1, '1, '1), ZERO_RES),
            cfg_row(eil_pkg::REG_ENTRY_COUNT, 32'd3),
            chk_row(req_row(eil_pkg::OP_SEARCH, 10'd0, '1, '1, 32'h0000_000F), MISS_RES),
            chk_row(req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, 32'h0000_0010),
                    hit_res(10'd0, 32'h0000_0010, 32'h80AB_CDEF, 1'b1)),
            chk_row(req_row(eil_pkg::OP_SEARCH, 10'd5, 32'h0, 32'h0, 32'h0000_0107),
                    hit_res(10'd0, 32'h0000_0010, 32'h80AB_CDEF, 1'b1)),
            chk_row(req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, 32'h0000_0108),
                    hit_res(10'd1, 32'h0000_0108, 32'hC000_0000, 1'b0)),
            chk_row(req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, '1),
                    hit_res(10'd2, 32'h4000_000F, 32'h3FFF_FFFF, 1'b0)),
            chk_row(req_row(eil_pkg::OP_WRITE, 10'd3, 32'h4000_0000, 32'h7FFF_FFFF, 32'h0),
                    ZERO_RES),
            cfg_row(eil_pkg::REG_ENTRY_COUNT, 32'd4),
            chk_row(req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, '1),
                    hit_res(10'd3, 32'hC000_0018, 32'hFFFF_FFFF, 1'b0)),
            chk_row(req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, 32'hC000_0017),
                    hit_res(10'd2, 32'h4000_000F, 32'h3FFF_FFFF, 1'b0)),
            cfg_row(eil_pkg::REG_TABLE_BASE, 32'hFFFF_FFF0),
            req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, 32'h0),
            req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, 32'h0000_00F7),
            cfg_row(eil_pkg::REG_TABLE_BASE, 32'hFFFF_FFFF),
            req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, 32'h8000_0000),
            cfg_row(eil_pkg::REG_ENTRY_COUNT, 32'd1),
            req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, 32'h0),
            req_row(eil_pkg::OP_SEARCH, 10'd0, 32'h0, 32'h0, '1)
        };

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (k = 0; k < NUM_DIR; k++) begin
            if (dir_tab[k].is_cfg) begin
                settle_idle();
                write_reg(dir_tab[k].reg_sel, dir_tab[k].reg_val);
            end else begin
                send_req(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].res);
            end
        end
        filled = 4;

        for (p = 0; p < NUM_PHASES; p++) begin
            n = PHASE_COUNTS[p];
            if (n > largest) largest = n;
            settle_idle();
            write_reg(eil_pkg::REG_TABLE_BASE,
                      (p == 5) ? 32'h0 : (p == 7) ? 32'hFFFF_FFFF : $urandom);
            write_reg(eil_pkg::REG_ENTRY_COUNT, 32'(n));
            tx_burst = ($urandom_range(0, 3) == 0);
            // entries below the count must have been written since reset
            if (n > filled || (n != 0 && n <= 64)) lay_sorted_table(n);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == PHASE_ITEMS / 2) settle_idle();
                rq = '{eil_pkg::OP_SEARCH, eil_pkg::SLOT_W'($urandom), $urandom, $urandom,
                       $urandom};
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    rq.op = eil_pkg::OP_WRITE;
                end else if (pick >= 15 && n > 0) begin
                    // aim at a table entry, the gap after it, or below the first one
                    fa = fn_addr_at($urandom_range(0, n - 1));
                    case ($urandom_range(0, 3))
                        0: rq.pc = fa;
                        1: rq.pc = fa + $urandom_range(1, 4095);
                        2: rq.pc = fa - 1;
                        default: rq.pc = fn_addr_at(0) - $urandom_range(1, 64);
                    endcase
                end
                send_req(rq);
            end
        end

        settle_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending.size()));
        end
        $display("covered %0d table writes and %0d searches (%0d hits, %0d inline, %0d misses)",
                 n_writes, n_hits + n_misses, n_hits, n_inline, n_misses);
        $display("across %0d base/count settings up to %0d entries; %0d results, %0d bad",
                 NUM_PHASES + 5, largest, n_results, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
